// ===== design/gfp_pkg.sv =====
// Shared types and constants of the grid rectangle first-fit placer.
package gfp_pkg;

  localparam int unsigned MaxColumns = 32;
  localparam int unsigned MaxRows    = 32;

  localparam logic CmdClear = 1'b0;
  localparam logic CmdPlace = 1'b1;

  localparam logic RegGridColumns = 1'b0;
  localparam logic RegGridRows    = 1'b1;

  typedef struct packed {
    logic       command;
    logic [5:0] request_tag;
    logic       is_pinned;
    logic [4:0] pin_column;
    logic [4:0] pin_row;
    logic [5:0] preferred_width;
    logic [5:0] minimum_width;
    logic [5:0] preferred_height;
    logic [5:0] minimum_height;
  } gfp_req_t;

  typedef struct packed {
    logic [5:0] tag_out;
    logic       was_placed;
    logic       pin_rejected;
    logic [4:0] placed_column;
    logic [4:0] placed_row;
    logic [5:0] placed_width;
    logic [5:0] placed_height;
  } gfp_res_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic setup;
    logic scan;
    logic mark;
    logic emit;
  } gfp_cmd_t;

  typedef struct packed {
    logic found;
    logic exhausted;
    logic mark_last;
  } gfp_sts_t;

endpackage

// ===== design/gfp_dp.sv =====
// Datapath of the placer: occupancy map, request registers and search engine.
module gfp_dp import gfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_wdata_i,
  input  gfp_req_t   req_i,
  input  gfp_cmd_t   cmd_i,
  output gfp_sts_t   sts_o,
  output gfp_res_t   res_o
);

  logic [31:0] map_q [MaxRows];
  logic [5:0]  cols_cfg_q, rows_cfg_q;
  logic [5:0]  px_q, mx_q, py_q, my_q;
  logic [5:0]  tag_q;
  logic        pin_q, rej_q, placed_q;
  logic        pin_req_q;
  logic [4:0]  pin_c_q, pin_r_q;
  logic [4:0]  c_q, r_q, oc_q, or_q;
  logic [5:0]  k_q, m_q, wsel_q, ow_q, oh_q, mk_q;

  logic [5:0] cols, rows;
  logic [5:0] px_n, mx_n, py_n, my_n, px_c, py_c;
  logic [5:0] mx_e, my_e, cap, hmax, run, new_m;
  logic [4:0] rd_row;
  logic [31:0] row_w, row_sh, mark_mask;
  logic [32:0] stop_v;
  logic in_min, fail, pin_fits;
  logic [6:0] nxt_c_end, nxt_r_end;

  always_comb begin
    cols = (cols_cfg_q == 6'd0) ? 6'd1 :
           (cols_cfg_q > 6'(MaxColumns)) ? 6'(MaxColumns) : cols_cfg_q;
    rows = (rows_cfg_q == 6'd0) ? 6'd1 :
           (rows_cfg_q > 6'(MaxRows)) ? 6'(MaxRows) : rows_cfg_q;
    px_n = (req_i.preferred_width  == 6'd0) ? 6'd1 : req_i.preferred_width;
    mx_n = (req_i.minimum_width    == 6'd0) ? 6'd1 : req_i.minimum_width;
    py_n = (req_i.preferred_height == 6'd0) ? 6'd1 : req_i.preferred_height;
    my_n = (req_i.minimum_height   == 6'd0) ? 6'd1 : req_i.minimum_height;
    px_c = (px_n > cols) ? cols : px_n;
    py_c = (py_n > rows) ? rows : py_n;
  end

  // The pin search reuses the flow engine with minimum spans equal to the
  // preferred spans.
  assign mx_e = pin_q ? px_q : mx_q;
  assign my_e = pin_q ? py_q : my_q;
  assign pin_fits = ({2'b0, pin_c_q} + {1'b0, px_q} <= {1'b0, cols}) &&
                    ({2'b0, pin_r_q} + {1'b0, py_q} <= {1'b0, rows});

  always_comb begin
    cap  = (px_q < cols - {1'b0, c_q}) ? px_q : cols - {1'b0, c_q};
    hmax = (py_q < rows - {1'b0, r_q}) ? py_q : rows - {1'b0, r_q};
    if (cmd_i.mark) rd_row = or_q + mk_q[4:0];
    else            rd_row = r_q + k_q[4:0] - 5'd1;
    row_w  = map_q[rd_row];
    row_sh = row_w >> c_q;
    mark_mask = (32'hFFFF_FFFF >> (6'd32 - ow_q)) << oc_q;
    // The free run from the current column ends at the first occupied unit
    // or at the span cap, whichever comes first.
    stop_v = {1'b0, row_sh} | (33'd1 << cap);
    run = 6'd32;
    for (int i = 32; i >= 0; i--) begin
      if (stop_v[i]) run = 6'(i);
    end
    new_m  = (k_q == 6'd1 || run < m_q) ? run : m_q;
    in_min = (k_q <= my_e);
    fail   = in_min && (new_m < mx_e);
    nxt_c_end = {2'b0, c_q} + 7'd1 + {1'b0, mx_q};
    nxt_r_end = {2'b0, r_q} + 7'd1 + {1'b0, my_q};
  end

  always_comb begin
    sts_o.found = 1'b0;
    sts_o.exhausted = 1'b0;
    if (in_min) begin
      sts_o.found = !fail && (k_q == hmax);
    end else begin
      sts_o.found = (new_m < wsel_q) || (k_q == hmax);
    end
    sts_o.exhausted = fail && !pin_q && (nxt_c_end > {1'b0, cols}) &&
                      (nxt_r_end > {1'b0, rows});
    sts_o.mark_last = (mk_q + 6'd1 == oh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxRows; i++) map_q[i] <= '0;
      cols_cfg_q <= 6'(MaxColumns);
      rows_cfg_q <= 6'(MaxRows);
    end else begin
      if (cfg_we_i && cfg_idx_i == RegGridColumns) cols_cfg_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == RegGridRows)    rows_cfg_q <= cfg_wdata_i;
      if (cmd_i.clear) begin
        for (int i = 0; i < MaxRows; i++) map_q[i] <= '0;
      end else if (cmd_i.mark) begin
        map_q[rd_row] <= row_w | mark_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear || cmd_i.load) begin
      tag_q <= req_i.request_tag;
      placed_q <= 1'b0;
      rej_q <= 1'b0;
      pin_q <= 1'b0;
      pin_req_q <= req_i.is_pinned;
      pin_c_q <= req_i.pin_column;
      pin_r_q <= req_i.pin_row;
      px_q <= px_c;
      py_q <= py_c;
      mx_q <= (mx_n > px_c) ? px_c : mx_n;
      my_q <= (my_n > py_c) ? py_c : my_n;
    end
    if (cmd_i.setup) begin
      k_q <= 6'd1;
      if (pin_req_q && pin_fits) begin
        pin_q <= 1'b1;
        c_q <= pin_c_q;
        r_q <= pin_r_q;
      end else begin
        rej_q <= pin_req_q;
        c_q <= '0;
        r_q <= '0;
      end
    end
    if (cmd_i.scan) begin
      if (sts_o.found) begin
        placed_q <= 1'b1;
        oc_q <= c_q;
        or_q <= r_q;
        mk_q <= '0;
        if (in_min) begin
          ow_q <= new_m;
          oh_q <= k_q;
        end else begin
          ow_q <= wsel_q;
          oh_q <= (new_m < wsel_q) ? k_q - 6'd1 : k_q;
        end
      end else if (fail) begin
        k_q <= 6'd1;
        if (pin_q) begin
          pin_q <= 1'b0;
          rej_q <= 1'b1;
          c_q <= '0;
          r_q <= '0;
        end else if (nxt_c_end > {1'b0, cols}) begin
          c_q <= '0;
          r_q <= r_q + 5'd1;
        end else begin
          c_q <= c_q + 5'd1;
        end
      end else begin
        k_q <= k_q + 6'd1;
        m_q <= new_m;
        if (k_q == my_e) wsel_q <= new_m;
      end
    end
    if (cmd_i.mark) mk_q <= mk_q + 6'd1;
  end

  always_comb begin
    res_o = '0;
    if (cmd_i.emit) begin
      res_o.tag_out = tag_q;
      res_o.pin_rejected = rej_q;
      res_o.was_placed = placed_q;
      if (placed_q) begin
        res_o.placed_column = oc_q;
        res_o.placed_row = or_q;
        res_o.placed_width = ow_q;
        res_o.placed_height = oh_q;
      end
    end
  end

endmodule

// ===== design/gfp_ctrl.sv =====
// Controller state machine of the placer.
module gfp_ctrl import gfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     command_i,
  input  gfp_sts_t sts_i,
  output gfp_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i == CmdClear) begin
            cmd_o.clear = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.load = 1'b1;
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) state_d = S_MARK;
        else if (sts_i.exhausted) state_d = S_DONE;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.mark_last) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted request left block idle");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !(sts_i.found && sts_i.exhausted))
    else $error("search both found and exhausted");

endmodule

// ===== design/grid_rectangle_first_fit_placer.sv =====
// Top level of the grid rectangle first-fit placer.
// A request is taken when start is high and busy low; its result appears
// for one cycle with done_o and cannot be held off. A clear goes straight
// from idle to the result state. A place request passes through setup, the
// search engine (one map row read per cycle, each position costing up to its
// height in rows) and, if a position is found, marking it row by row.
module grid_rectangle_first_fit_placer import gfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  gfp_req_t   req_i,
  output logic       done_o,
  output gfp_res_t   res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_wdata_i
);

  gfp_cmd_t cmd;
  gfp_sts_t sts;

  gfp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start),
    .command_i(req_i.command),
    .sts_i(sts),
    .cmd_o(cmd),
    .busy_o(busy),
    .done_o
  );

  gfp_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .req_i,
    .cmd_i(cmd),
    .sts_o(sts),
    .res_o
  );

endmodule

// ===== tb/grid_rectangle_first_fit_placer_tb.sv =====
// Self-checking testbench for the grid rectangle first-fit placer.
`timescale 1ns / 100ps

import gfp_pkg::*;

class placement_scoreboard;
  logic [31:0] occupied [MaxRows];
  int unsigned grid_cols;
  int unsigned grid_rows;
  gfp_res_t    pending_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned placed_seen;
  int unsigned rejected_seen;

  function new();
    foreach (occupied[i]) occupied[i] = '0;
    grid_cols = 32;
    grid_rows = 32;
    mismatches = 0;
    results_seen = 0;
    placed_seen = 0;
    rejected_seen = 0;
  endfunction

  function void set_register(logic idx, logic [5:0] value);
    if (idx == RegGridColumns) grid_cols = {26'd0, value};
    else grid_rows = {26'd0, value};
  endfunction

  function logic [31:0] span_bits(int unsigned col, int unsigned span);
    logic [63:0] m;
    m = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
    m = m << col;
    return m[31:0];
  endfunction

  function bit region_free(int unsigned col, int unsigned row, int unsigned sx,
                           int unsigned sy);
    logic [31:0] m;
    m = span_bits(col, sx);
    for (int unsigned r = row; r < row + sy; r++) begin
      if (r >= MaxRows) return 0;
      if ((occupied[r] & m) != 0) return 0;
    end
    return 1;
  endfunction

  function int unsigned at_least_one(logic [5:0] v);
    return (v == 6'd0) ? 1 : {26'd0, v};
  endfunction

  // Computes the outcome of one accepted request and queues it.
  function void note_request(gfp_req_t req);
    gfp_res_t    res;
    int unsigned cols, rows, px, mx, py, my, pc, pr;
    bit          found;
    logic [31:0] m;

    res = '0;
    res.tag_out = req.request_tag;
    found = 0;
    if (req.command == CmdClear) begin
      foreach (occupied[i]) occupied[i] = '0;
      pending_q.push_back(res);
      return;
    end
    cols = (grid_cols < 1) ? 1 : ((grid_cols > MaxColumns) ? MaxColumns : grid_cols);
    rows = (grid_rows < 1) ? 1 : ((grid_rows > MaxRows) ? MaxRows : grid_rows);
    px = at_least_one(req.preferred_width);
    mx = at_least_one(req.minimum_width);
    py = at_least_one(req.preferred_height);
    my = at_least_one(req.minimum_height);
    if (px > cols) px = cols;
    if (py > rows) py = rows;
    if (mx > px) mx = px;
    if (my > py) my = py;

    if (req.is_pinned) begin
      pc = {27'd0, req.pin_column};
      pr = {27'd0, req.pin_row};
      if (pc + px <= cols && pr + py <= rows && region_free(pc, pr, px, py)) begin
        found = 1;
        res.placed_column = 5'(pc);
        res.placed_row = 5'(pr);
        res.placed_width = 6'(px);
        res.placed_height = 6'(py);
      end else begin
        res.pin_rejected = 1'b1;
      end
    end

    for (int unsigned r = 0; !found && r + my <= rows; r++)
      for (int unsigned c = 0; !found && c + mx <= cols; c++)
        for (int unsigned sx = px; !found && sx >= mx; sx--) begin
          if (c + sx > cols) continue;
          for (int unsigned sy = py; !found && sy >= my; sy--) begin
            if (r + sy > rows) continue;
            if (region_free(c, r, sx, sy)) begin
              found = 1;
              res.placed_column = 5'(c);
              res.placed_row = 5'(r);
              res.placed_width = 6'(sx);
              res.placed_height = 6'(sy);
            end
          end
        end

    if (found) begin
      res.was_placed = 1'b1;
      m = span_bits(res.placed_column, res.placed_width);
      for (int unsigned r = res.placed_row;
           r < res.placed_row + res.placed_height && r < MaxRows; r++)
        occupied[r] |= m;
    end
    pending_q.push_back(res);
  endfunction

  function void check_result(gfp_res_t got);
    gfp_res_t want;
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending_q.pop_front();
    if (got.was_placed) placed_seen++;
    if (got.pin_rejected) rejected_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module grid_rectangle_first_fit_placer_tb;
  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  gfp_req_t   req;
  logic       done;
  gfp_res_t   res;
  logic       cfg_we;
  logic       cfg_idx;
  logic [5:0] cfg_wdata;

  placement_scoreboard board;
  int unsigned         items_sent;
  int unsigned         cur_grid;

  grid_rectangle_first_fit_placer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1s;
    $display("timeout with %0d results outstanding", board.pending_q.size());
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && done) board.check_result(res);
  end

  // Issues one request, then keeps start low for the given number of cycles.
  task automatic send_request(gfp_req_t item, int unsigned gap);
    req <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_request(item);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [5:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_register(idx, value);
  endtask

  function automatic gfp_req_t make_place(logic [5:0] tag, bit pinned, int pc, int pr,
                                          int pw, int mw, int ph, int mh);
    gfp_req_t r;
    r.command = CmdPlace;
    r.request_tag = tag;
    r.is_pinned = pinned;
    r.pin_column = 5'(pc);
    r.pin_row = 5'(pr);
    r.preferred_width = 6'(pw);
    r.minimum_width = 6'(mw);
    r.preferred_height = 6'(ph);
    r.minimum_height = 6'(mh);
    return r;
  endfunction

  function automatic gfp_req_t make_clear(logic [5:0] tag);
    gfp_req_t r;
    r = gfp_req_t'($urandom);
    r.command = CmdClear;
    r.request_tag = tag;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  function automatic int unsigned pick_grid();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 32;
      3: return $urandom_range(33, 63);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  // Keeps the search cheap: narrow min-to-preferred ranges, occasional full spans.
  function automatic gfp_req_t random_place(int unsigned grid);
    int pw, mw, ph, mh, lim;
    lim = (grid > 8 || grid == 0) ? 8 : grid + 1;
    pw = $urandom_range(0, lim);
    ph = $urandom_range(0, lim);
    if ($urandom_range(0, 15) == 0) pw = 32;
    if ($urandom_range(0, 15) == 0) ph = 32;
    mw = (pw > 2) ? pw - $urandom_range(0, 2) : $urandom_range(0, 2);
    mh = (ph > 2) ? ph - $urandom_range(0, 2) : $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) mw = $urandom_range(0, 32);
    if ($urandom_range(0, 9) == 0) mh = $urandom_range(0, 32);
    if (pw >= 16 && mw < pw - 2) mw = pw;
    if (ph >= 16 && mh < ph - 2) mh = ph;
    return make_place(6'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 31),
                      $urandom_range(0, 31), pw, mw, ph, mh);
  endfunction

  initial begin
    bit quiet;
    board = new();
    items_sent = 0;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_idx = RegGridColumns;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero spans, pins in and out of bounds, occupied pins,
    // minimum above preferred, full-grid spans and clears.
    send_request(make_clear(6'd63), 0);
    send_request(make_place(6'd0, 0, 31, 31, 0, 0, 0, 0), 1);
    send_request(make_place(6'd1, 1, 31, 31, 1, 1, 1, 1), 0);
    send_request(make_place(6'd2, 1, 0, 0, 1, 0, 1, 0), 2);
    send_request(make_place(6'd3, 1, 30, 5, 4, 4, 2, 2), 0);
    send_request(make_place(6'd4, 0, 0, 0, 2, 5, 3, 7), 0);
    send_request(make_place(6'd5, 0, 0, 0, 32, 32, 32, 32), 1);
    send_request(make_place(6'd6, 1, 4, 4, 32, 32, 1, 1), 0);
    send_request(make_clear(6'd7), 0);
    send_request(make_place(6'd8, 1, 0, 0, 32, 32, 32, 32), 0);
    send_request(make_place(6'd9, 1, 16, 16, 1, 1, 1, 1), 3);
    send_request(make_place(6'd10, 0, 0, 0, 0, 0, 0, 0), 0);
    send_request(make_clear(6'd11), 0);
    send_request(make_place(6'd12, 1, 31, 0, 33 - 1, 1, 1, 1), 0);
    send_request(make_place(6'd13, 0, 0, 0, 31, 31, 31, 31), 0);
    wait_idle();
    write_register(RegGridColumns, 6'd0);
    write_register(RegGridRows, 6'd63);
    send_request(make_place(6'd14, 1, 0, 1, 2, 2, 40 - 8, 32), 0);
    send_request(make_place(6'd15, 1, 0, 0, 0, 0, 0, 0), 0);
    send_request(make_place(6'd16, 0, 0, 0, 1, 1, 1, 1), 0);
    wait_idle();

    while (items_sent < 1550) begin
      cur_grid = pick_grid();
      write_register(RegGridColumns, 6'(cur_grid));
      write_register(RegGridRows, 6'($urandom_range(0, 1) ? cur_grid : pick_grid()));
      send_request(make_clear(6'($urandom)), 0);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 11) == 0) send_request(make_clear(6'($urandom)), pick_gap(quiet));
        else send_request(random_place(cur_grid), pick_gap(quiet));
      end
      wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Sent %0d requests over many grid settings; %0d results checked,",
             items_sent, board.results_seen);
    $display("%0d placed and %0d with a refused pin.", board.placed_seen,
             board.rejected_seen);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_q.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule
